// ----- sv/stft_pkg.sv -----
`default_nettype none
package stft_pkg;
  localparam int FftPoints  = 64;
  localparam int SampleBits = 16;
  localparam int HalfPoints = FftPoints / 2;
  localparam int IdxW       = $clog2(FftPoints);
  localparam int TwStep     = 64 / FftPoints;
  localparam int HopW       = 7;
  localparam int BinW       = 6;
  localparam int WinW       = 22;
  localparam int AccW       = 64;

  localparam logic [HopW-1:0] HopReset = 7'd32;

  typedef enum logic [0:0] {
    FUNC_COEF   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  function automatic logic signed [17:0] quarter_cos(input logic [4:0] i);
    logic signed [17:0] r;
    case (i)
      5'd0:  r = 18'sd32768;
      5'd1:  r = 18'sd32610;
      5'd2:  r = 18'sd32138;
      5'd3:  r = 18'sd31357;
      5'd4:  r = 18'sd30274;
      5'd5:  r = 18'sd28899;
      5'd6:  r = 18'sd27246;
      5'd7:  r = 18'sd25330;
      5'd8:  r = 18'sd23170;
      5'd9:  r = 18'sd20788;
      5'd10: r = 18'sd18205;
      5'd11: r = 18'sd15447;
      5'd12: r = 18'sd12540;
      5'd13: r = 18'sd9512;
      5'd14: r = 18'sd6393;
      5'd15: r = 18'sd3212;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  // cosine of i*pi/32, full circle over 64 steps
  function automatic logic signed [17:0] cos64(input logic [5:0] i);
    logic signed [17:0] r;
    if (i <= 6'd16) r = quarter_cos(i[4:0]);
    else if (i <= 6'd32) r = -quarter_cos(5'(6'd32 - i));
    else if (i <= 6'd48) r = -quarter_cos(5'(i - 6'd32));
    else r = quarter_cos(5'(7'd64 - {1'b0, i}));
    return r;
  endfunction

  function automatic logic signed [17:0] cordic_angle(input logic [3:0] i);
    logic signed [17:0] r;
    case (i)
      4'd0:  r = 18'sd8192;
      4'd1:  r = 18'sd4836;
      4'd2:  r = 18'sd2555;
      4'd3:  r = 18'sd1297;
      4'd4:  r = 18'sd651;
      4'd5:  r = 18'sd326;
      4'd6:  r = 18'sd163;
      4'd7:  r = 18'sd81;
      4'd8:  r = 18'sd41;
      4'd9:  r = 18'sd20;
      4'd10: r = 18'sd10;
      4'd11: r = 18'sd5;
      4'd12: r = 18'sd3;
      4'd13: r = 18'sd1;
      4'd14: r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- sv/stft_magnitude_phase_top.sv -----
// A sample that closes a frame runs a window pass, then loads its bins one after another,
//   each through a MAC pass, prep, CORDIC, gain, divide and load.
// Flow: one item in flight; a held bin delays the next only if it is still held when the next
//   is ready to load.
// Reset (rst, synchronous): clears control, counters, window valid bits and sum; hop to 32.
`default_nettype none
module stft_magnitude_phase_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        func,
  input  wire logic [5:0]                  coef_index,
  input  wire logic [15:0]                 coef_value,
  input  wire logic signed [15:0]          sample_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [5:0]                       bin_index,
  output logic [15:0]                      magnitude,
  output logic signed [15:0]               phase,
  output logic [31:0]                      frame_start,
  output logic                             last_bin,
  input  wire logic                        cfg_we,
  input  wire logic [6:0]                  cfg_wdata
);
  import stft_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ITEM  = 9'b000000010,
    S_WIN   = 9'b000000100,
    S_MAC   = 9'b000001000,
    S_PREP  = 9'b000010000,
    S_CORD  = 9'b000100000,
    S_GAIN  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;

  // captured item
  logic              it_func;
  logic [IdxW-1:0]   it_idx;
  logic              it_idx_ok;
  logic [15:0]       it_coef;
  logic signed [SampleBits-1:0] it_samp;

  logic [HopW-1:0]   hop_length;
  logic [31:0]       samples_seen;
  logic [HopW-1:0]   hop_countdown;
  logic              ring_full;
  logic [WinW-1:0]   window_total;

  // memories: sample ring, window table, windowed frame
  logic signed [SampleBits-1:0] ring [FftPoints];
  logic [15:0]       win_mem [FftPoints];
  logic [FftPoints-1:0] win_valid;
  logic signed [SampleBits+16:0] xbuf [FftPoints];

  logic [IdxW-1:0]   newest;
  logic [IdxW:0]     n;
  logic [BinW-1:0]   k;
  logic              phase2;
  logic signed [SampleBits-1:0] ring_q;
  logic [15:0]       win_q;
  logic signed [SampleBits+16:0] x_q;
  logic signed [AccW-1:0] acc_re, acc_im;
  logic signed [AccW-1:0] cx, cy;
  logic signed [17:0] z;
  logic [3:0]        ci;
  logic [63:0]       gnum, quot, rem;
  logic [6:0]        dcnt;
  logic [WinW:0]     dden;
  logic              zero_bin;

  logic [HopW-1:0]   eff_hop;
  always_comb begin
    if (hop_length == '0) eff_hop = HopW'(1);
    else if (hop_length > HopW'(FftPoints)) eff_hop = HopW'(FftPoints);
    else eff_hop = hop_length;
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) hop_length <= HopReset;
    else if (cfg_we) hop_length <= cfg_wdata;
  end

  // twiddle index: k*n*TwStep modulo 64
  logic [5:0] tw;
  logic [11:0] kn;
  assign kn = 12'(k) * 12'(n[IdxW-1:0]) * 12'(TwStep);
  assign tw = kn[5:0];

  logic signed [17:0] tw_sel;
  assign tw_sel = phase2 ? cos64(6'(tw + 6'd48)) : cos64(tw);

  logic signed [AccW-1:0] prod;
  assign prod = AccW'(x_q) * AccW'(tw_sel);

  function automatic logic signed [AccW-1:0] trunc15(input logic signed [AccW-1:0] v);
    logic [AccW-1:0] m;
    if (v >= 0) return v >>> 15;
    m = AccW'(-v) >> 15;
    return -$signed(m);
  endfunction

  logic signed [AccW-1:0] dx, dy;
  assign dx = cy >>> ci;
  assign dy = cx >>> ci;

  // restoring divide step
  logic [WinW+1:0] rtrial;
  assign rtrial = {rem[WinW:0], quot[63]} - {1'b0, dden};

  // output register: set when a bin is loaded, drop once it has been taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == S_EMIT && !out_valid) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      samples_seen <= '0;
      hop_countdown <= '0;
      ring_full <= 1'b0;
      window_total <= '0;
      win_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            it_func   <= func;
            it_idx    <= coef_index[IdxW-1:0];
            it_idx_ok <= ({1'b0, coef_index} < 7'(FftPoints));
            it_coef   <= coef_value;
            it_samp   <= sample_value[SampleBits-1:0];
            state     <= S_ITEM;
          end
        end
        S_ITEM: begin
          if (it_func == FUNC_COEF) begin
            // win_q holds the old entry, read at the transfer edge
            if (it_idx_ok) begin
              window_total <= window_total - WinW'(win_q) + WinW'(it_coef);
              win_valid[it_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            samples_seen <= samples_seen + 32'd1;
            newest <= samples_seen[IdxW-1:0];
            n <= '0;
            state <= S_IDLE;
            if (!ring_full) begin
              if (samples_seen + 32'd1 >= 32'(FftPoints)) begin
                ring_full <= 1'b1;
                hop_countdown <= eff_hop;
                state <= S_WIN;
              end
            end else if (hop_countdown <= HopW'(1)) begin
              hop_countdown <= eff_hop;
              state <= S_WIN;
            end else begin
              hop_countdown <= hop_countdown - HopW'(1);
            end
            phase2 <= 1'b0;
          end
        end
        S_WIN: begin
          // phase2 low: read issued; high: product written
          if (!phase2) phase2 <= 1'b1;
          else begin
            phase2 <= 1'b0;
            if (n == (IdxW+1)'(FftPoints - 1)) begin
              n <= '0;
              k <= '0;
              acc_re <= '0;
              acc_im <= '0;
              state <= S_MAC;
            end else n <= n + 1'b1;
          end
        end
        S_MAC: begin
          // each n: re pass then im pass, sharing one multiplier
          if (!phase2) begin
            acc_re <= acc_re + prod;
            phase2 <= 1'b1;
          end else begin
            acc_im <= acc_im - prod;
            phase2 <= 1'b0;
            if (n == (IdxW+1)'(FftPoints - 1)) state <= S_PREP;
            else n <= n + 1'b1;
          end
        end
        S_PREP: begin
          ci <= '0;
          zero_bin <= (trunc15(acc_re) == 0) && (trunc15(acc_im) == 0);
          if (trunc15(acc_re) < 0) begin
            cx <= -trunc15(acc_re);
            cy <= -trunc15(acc_im);
            z <= (trunc15(acc_im) >= 0) ? 18'sd32768 : -18'sd32768;
          end else begin
            cx <= trunc15(acc_re);
            cy <= trunc15(acc_im);
            z <= '0;
          end
          state <= S_CORD;
        end
        S_CORD: begin
          if (cy >= 0) begin
            cx <= cx + dx;
            cy <= cy - dy;
            z  <= z + cordic_angle(ci);
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            z  <= z - cordic_angle(ci);
          end
          ci <= ci + 4'd1;
          if (ci == 4'd15) state <= S_GAIN;
        end
        S_GAIN: begin
          // g = round(cx*19899 / 2^15); numerator = 2*g*d + wt
          gnum <= 64'((64'(cx) * 64'd19899 + 64'd16384) >> 15);
          state <= S_DIV;
          dcnt <= '0;
          phase2 <= 1'b0;
        end
        S_DIV: begin
          if (!phase2) begin
            quot <= ((k == '0 || k == BinW'(HalfPoints)) ? (gnum << 1) : (gnum << 2))
                    + 64'(window_total);
            rem <= '0;
            dden <= {window_total, 1'b0};
            phase2 <= 1'b1;
          end else begin
            if (!rtrial[WinW+1]) rem <= 64'(rtrial);
            else rem <= {rem[62:0], quot[63]};
            quot <= {quot[62:0], !rtrial[WinW+1]};
            dcnt <= dcnt + 7'd1;
            if (dcnt == 7'd63) state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the previous bin has gone, then load it and advance
          if (!out_valid) begin
            bin_index <= k;
            if (zero_bin || window_total == '0) magnitude <= '0;
            else if (quot > 64'd65535) magnitude <= 16'hFFFF;
            else magnitude <= quot[15:0];
            phase <= zero_bin ? 16'sd0 : z[15:0];
            frame_start <= samples_seen - 32'(FftPoints);
            last_bin <= (k == BinW'(HalfPoints));
            phase2 <= 1'b0;
            n <= '0;
            acc_re <= '0;
            acc_im <= '0;
            if (k == BinW'(HalfPoints)) state <= S_IDLE;
            else begin
              k <= k + 1'b1;
              state <= S_MAC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memories: writes and registered reads
  logic [IdxW-1:0] rd_pos;
  assign rd_pos = IdxW'(newest + IdxW'(1) + n[IdxW-1:0]);

  // window read: the entry being replaced while idle, the frame position otherwise
  logic [IdxW-1:0] win_rd;
  assign win_rd = (state == S_IDLE) ? coef_index[IdxW-1:0] : n[IdxW-1:0];

  // frame read runs one step ahead so that x_q holds x[n] through both MAC passes
  logic [IdxW-1:0] x_rd;
  assign x_rd = (state == S_MAC && !phase2) ? n[IdxW-1:0] : IdxW'(n[IdxW-1:0] + IdxW'(1));

  always_ff @(posedge clk) begin
    if (state == S_ITEM && it_func == FUNC_COEF && it_idx_ok) win_mem[it_idx] <= it_coef;
    if (state == S_ITEM && it_func == FUNC_SAMPLE) ring[samples_seen[IdxW-1:0]] <= it_samp;
    ring_q <= ring[rd_pos];
    win_q  <= win_valid[win_rd] ? win_mem[win_rd] : 16'd0;
    if (state == S_WIN && phase2)
      xbuf[n[IdxW-1:0]] <= (SampleBits+17)'(ring_q) * $signed({1'b0, win_q});
    x_q <= xbuf[x_rd];
  end

`ifndef SYNTHESIS
  a_emit_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !out_valid) |=> out_valid) else $error("bin not loaded");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(magnitude))
    else $error("stalled result changed");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_bin) |-> bin_index == BinW'(HalfPoints)) else $error("bad last bin");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("ready while busy");
`endif
endmodule
`default_nettype wire
